[src/ntpl_pkg.sv]
// ntpl_pkg: constants, stage types and helper functions for ntp_timestamp_to_local_time.
// No dependencies.

package ntpl_pkg;

    localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
    localparam logic [16:0] SECS_HOUR       = 17'd3600;
    localparam logic [16:0] SECS_DAY        = 17'd86400;

    // floor(x / 675) for x < 2^25: (x * DAY_RECIP) >> 35
    localparam logic [25:0] DAY_RECIP       = 26'd50903317;
    // year estimate: (days * YEAR_RECIP) >> 20, within one of the true year
    localparam logic [11:0] YEAR_RECIP      = 12'd2871;
    // floor(x / 225) for x < 2^13: (x * HOUR_RECIP) >> 21
    localparam logic [13:0] HOUR_RECIP      = 14'd9321;
    // floor(x / 7) for x < 2^12: (x * SEVEN_RECIP) >> 15
    localparam logic [12:0] SEVEN_RECIP     = 13'd4682;

    localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
    localparam logic [7:0]  YI_2100         = 8'd130;

    localparam logic [8:0]  MARCH_DOY       = 9'd59;
    localparam logic [8:0]  APRIL_DOY       = 9'd90;
    localparam logic [8:0]  OCTOBER_DOY     = 9'd273;
    localparam logic [8:0]  NOVEMBER_DOY    = 9'd304;

    localparam logic REG_ZONE = 1'b0;
    localparam logic REG_DST  = 1'b1;

    typedef enum logic [1:0] {
        SEASON_WINTER,
        SEASON_MARCH,
        SEASON_SUMMER,
        SEASON_OCTOBER
    } season_t;

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] days;
    } days_stage_t;

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] days;
        logic [7:0]  yest;
        logic [16:0] sod;
    } split_stage_t;

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] days;
        logic [7:0]  yest;
        logic [4:0]  hour;
        logic [16:0] start_lo;
        logic [16:0] start_mid;
        logic [16:0] start_hi;
    } start_stage_t;

    typedef struct packed {
        logic [31:0] t;
        logic [4:0]  hour;
        logic [7:0]  yi;
        logic [8:0]  doy;
        logic        leap;
    } year_stage_t;

    typedef struct packed {
        logic [31:0] t;
        logic [4:0]  hour;
        season_t     season;
        logic [4:0]  mday;
        logic [2:0]  r_mar;
        logic [2:0]  r_oct;
    } month_stage_t;

    // days from 1970-01-01 to 1 January of year 1970+yi (2100 is not leap)
    function automatic logic [16:0] year_start(input logic [7:0] yi);
        logic [8:0]  yp;
        logic [16:0] base;
        yp   = {1'b0, yi} + 9'd1;
        base = 17'(yi) * 17'd365 + 17'(yp[8:2]);
        if (yi > YI_2100)
        begin
            base = base - 17'd1;
        end
        return base;
    endfunction

    function automatic logic [2:0] mod7(input logic [11:0] v);
        logic [24:0] prod;
        logic [9:0]  q;
        logic [11:0] r;
        prod = 25'(v) * 25'(SEVEN_RECIP);
        q    = prod[24:15];
        r    = v - ({q, 2'b00} + {1'b0, q, 1'b0} + {2'b00, q});
        return r[2:0];
    endfunction

endpackage

[src/ntp_timestamp_to_local_time.sv]
// ntp_timestamp_to_local_time: NTP transmit seconds to local Unix time with EU summer time.
// Seven-stage pipeline with an APB register port. Depends on ntpl_pkg.
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+-------------------------------------
//   timestamp | in        | start, busy            | ts_byte_msb, ts_byte_2, ts_byte_1, ts_byte_lsb
//   result    | out       | done (one-cycle strobe)| local_seconds, dst_applied
//   config    | in        | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// One timestamp per cycle; busy is never raised.
// An accepted transfer moves through the stages below in order and comes out with done.
// Stages: offset/zone add, day divide, year estimate and second-of-day, hour and year
// starts, year fix, month and last-Sunday, summer decision and result register.
// Reset clears the stage valid bits and the two registers; no clearing pass.
// The receiver cannot stall, so nothing holds in the pipeline.

module ntp_timestamp_to_local_time
    import ntpl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  ts_byte_msb,
    input  logic [7:0]  ts_byte_2,
    input  logic [7:0]  ts_byte_1,
    input  logic [7:0]  ts_byte_lsb,
    output logic        done,
    output logic [31:0] local_seconds,
    output logic        dst_applied
);

    logic signed [4:0] zone_reg;
    logic              dst_en_reg;
    logic [7:1]        valid_reg;

    logic [31:0]       t1_reg;
    days_stage_t       s2_reg;
    split_stage_t      s3_reg;
    start_stage_t      s4_reg;
    year_stage_t       s5_reg;
    month_stage_t      s6_reg;
    logic [31:0]       local_seconds_reg;
    logic              dst_applied_reg;

    logic [31:0]       t1_next;
    days_stage_t       s2_next;
    split_stage_t      s3_next;
    start_stage_t      s4_next;
    year_stage_t       s5_next;
    month_stage_t      s6_next;
    logic [31:0]       local_seconds_next;
    logic              dst_applied_next;

    logic              accept;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg   <= '0;
            dst_en_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_ZONE: zone_reg   <= signed'(pwdata[4:0]);
                REG_DST:  dst_en_reg <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ZONE: prdata = {27'd0, zone_reg};
            REG_DST:  prdata = {31'd0, dst_en_reg};
            default:  prdata = '0;
        endcase
    end

    // stage 1: seconds since 1970 in local standard time
    logic signed [16:0] zone_secs;

    always_comb
    begin
        zone_secs = 17'(zone_reg) * signed'(SECS_HOUR);
        t1_next   = {ts_byte_msb, ts_byte_2, ts_byte_1, ts_byte_lsb} - NTP_UNIX_OFFSET
                    + 32'(zone_secs);
    end

    // stage 2: whole days
    logic [50:0] day_prod;

    always_comb
    begin
        day_prod    = 51'(t1_reg[31:7]) * 51'(DAY_RECIP);
        s2_next.t    = t1_reg;
        s2_next.days = day_prod[50:35];
    end

    // stage 3: year estimate and second of day
    logic [27:0] year_prod;
    logic [32:0] day_secs;

    always_comb
    begin
        year_prod    = 28'(s2_reg.days) * 28'(YEAR_RECIP);
        day_secs     = 33'(s2_reg.days) * 33'(SECS_DAY);
        s3_next.t    = s2_reg.t;
        s3_next.days = s2_reg.days;
        s3_next.yest = year_prod[27:20];
        s3_next.sod  = s2_reg.t[16:0] - day_secs[16:0];
    end

    // stage 4: hour of day and starts of the neighbouring years
    logic [26:0] hour_prod;

    always_comb
    begin
        hour_prod         = 27'(s3_reg.sod[16:4]) * 27'(HOUR_RECIP);
        s4_next.t         = s3_reg.t;
        s4_next.days      = s3_reg.days;
        s4_next.yest      = s3_reg.yest;
        s4_next.hour      = hour_prod[25:21];
        s4_next.start_lo  = year_start(s3_reg.yest - 8'd1);
        s4_next.start_mid = year_start(s3_reg.yest);
        s4_next.start_hi  = year_start(s3_reg.yest + 8'd1);
    end

    // stage 5: exact year and day of year
    logic [16:0] start_sel;
    logic [16:0] doy_full;

    always_comb
    begin
        s5_next.t    = s4_reg.t;
        s5_next.hour = s4_reg.hour;
        if (17'(s4_reg.days) < s4_reg.start_mid)
        begin
            s5_next.yi = s4_reg.yest - 8'd1;
            start_sel  = s4_reg.start_lo;
        end
        else if (17'(s4_reg.days) >= s4_reg.start_hi)
        begin
            s5_next.yi = s4_reg.yest + 8'd1;
            start_sel  = s4_reg.start_hi;
        end
        else
        begin
            s5_next.yi = s4_reg.yest;
            start_sel  = s4_reg.start_mid;
        end
        doy_full     = 17'(s4_reg.days) - start_sel;
        s5_next.doy  = doy_full[8:0];
        s5_next.leap = (s5_next.yi[1:0] == 2'd2) && (s5_next.yi != YI_2100);
    end

    // stage 6: month class, day of month, last-Sunday offsets
    logic [11:0] year_num;
    logic [13:0] year_x5;
    logic [11:0] sun_base;
    logic [8:0]  leap9;
    logic [8:0]  mday_full;

    always_comb
    begin
        year_num  = EPOCH_YEAR + 12'(s5_reg.yi);
        year_x5   = {year_num, 2'b00} + 14'(year_num);
        sun_base  = year_x5[13:2];
        leap9     = 9'(s5_reg.leap);
        mday_full = '0;

        s6_next.t     = s5_reg.t;
        s6_next.hour  = s5_reg.hour;
        s6_next.r_mar = mod7(sun_base + 12'd4);
        s6_next.r_oct = mod7(sun_base + 12'd1);

        if (s5_reg.doy < MARCH_DOY + leap9)
        begin
            s6_next.season = SEASON_WINTER;
        end
        else if (s5_reg.doy < APRIL_DOY + leap9)
        begin
            s6_next.season = SEASON_MARCH;
            mday_full      = s5_reg.doy - MARCH_DOY - leap9 + 9'd1;
        end
        else if (s5_reg.doy < OCTOBER_DOY + leap9)
        begin
            s6_next.season = SEASON_SUMMER;
        end
        else if (s5_reg.doy < NOVEMBER_DOY + leap9)
        begin
            s6_next.season = SEASON_OCTOBER;
            mday_full      = s5_reg.doy - OCTOBER_DOY - leap9 + 9'd1;
        end
        else
        begin
            s6_next.season = SEASON_WINTER;
        end
        s6_next.mday = mday_full[4:0];
    end

    // stage 7: switch instant and result
    logic signed [10:0] hour_pos;
    logic signed [10:0] lim_mar;
    logic signed [10:0] lim_oct;
    logic               summer;

    always_comb
    begin
        hour_pos = signed'(11'(s6_reg.hour) + 11'(s6_reg.mday) * 11'd24);
        lim_mar  = 11'sd1 + 11'(zone_reg)
                   + signed'(11'd24 * (11'd31 - 11'(s6_reg.r_mar)));
        lim_oct  = 11'sd1 + 11'(zone_reg)
                   + signed'(11'd24 * (11'd31 - 11'(s6_reg.r_oct)));
        case (s6_reg.season)
            SEASON_WINTER:  summer = 1'b0;
            SEASON_MARCH:   summer = hour_pos >= lim_mar;
            SEASON_SUMMER:  summer = 1'b1;
            SEASON_OCTOBER: summer = hour_pos < lim_oct;
            default:        summer = 1'b0;
        endcase
        dst_applied_next   = dst_en_reg && summer;
        local_seconds_next = s6_reg.t + (dst_applied_next ? 32'(SECS_HOUR) : 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[6:1], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg            <= t1_next;
        s2_reg            <= s2_next;
        s3_reg            <= s3_next;
        s4_reg            <= s4_next;
        s5_reg            <= s5_next;
        s6_reg            <= s6_next;
        local_seconds_reg <= local_seconds_next;
        dst_applied_reg   <= dst_applied_next;
    end

    assign done          = valid_reg[7];
    assign local_seconds = local_seconds_reg;
    assign dst_applied   = dst_applied_reg && valid_reg[7];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##7 done)
        else $error("transfer did not complete after seven cycles");

    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> s4_reg.hour < 5'd24)
        else $error("hour of day out of range");

    a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> (s5_reg.doy < 9'd365 + 9'(s5_reg.leap)) && (s5_reg.yi <= 8'd136))
        else $error("year or day of year out of range");

    a_dst_off: assert property (@(posedge clk) disable iff (!rst_n)
        done && !$past(dst_en_reg) |-> !dst_applied)
        else $error("summer hour added with daylight handling off");

endmodule

[test/tb_ntp_timestamp_to_local_time.sv]
// tb_ntp_timestamp_to_local_time: self-checking bench for ntp_timestamp_to_local_time.
// Predicts local Unix time and the summer time flag for every timestamp transfer and
// compares each result strobe in order. Depends on ntpl_pkg and the block itself.

module tb_ntp_timestamp_to_local_time;
    import ntpl_pkg::*;

    typedef struct {
        logic [31:0] secs;
        logic        dst;
    } local_time_t;

    class local_time_board;
        logic [4:0]  zone_reg;
        logic        dst_on;
        local_time_t expected_times[$];
        int          failures;

        function new();
            zone_reg = 5'd0;
            dst_on   = 1'b0;
            failures = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] data);
            if (idx == REG_ZONE)
            begin
                zone_reg = data[4:0];
            end
            else
            begin
                dst_on = data[0];
            end
        endfunction

        function bit leap(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        // m counts from 0 for January
        function int unsigned month_len(int unsigned m, int unsigned y);
            case (m)
                1:         return leap(y) ? 29 : 28;
                3, 5, 8, 10: return 30;
                default:   return 31;
            endcase
        endfunction

        // EU rule, evaluated on local standard time
        function bit summer(logic [31:0] t, int zone);
            int unsigned days;
            int unsigned year;
            int unsigned m;
            int unsigned ylen;
            int unsigned mlen;
            int          hour;
            int          mday;
            int          limit;
            days = t / 32'd86400;
            hour = int'((t % 32'd86400) / 32'd3600);
            year = 1970;
            m    = 0;
            ylen = leap(year) ? 366 : 365;
            while (days >= ylen)
            begin
                days = days - ylen;
                year = year + 1;
                ylen = leap(year) ? 366 : 365;
            end
            mlen = month_len(m, year);
            while (days >= mlen && m != 11)
            begin
                days = days - mlen;
                m    = m + 1;
                mlen = month_len(m, year);
            end
            m    = m + 1;
            mday = int'(days) + 1;
            if (m < 3 || m > 10)
            begin
                return 1'b0;
            end
            if (m > 3 && m < 10)
            begin
                return 1'b1;
            end
            if (m == 3)
            begin
                limit = 1 + zone + 24 * (31 - int'((5 * year / 4 + 4) % 7));
                return (hour + 24 * mday) >= limit;
            end
            limit = 1 + zone + 24 * (31 - int'((5 * year / 4 + 1) % 7));
            return (hour + 24 * mday) < limit;
        endfunction

        function void note_timestamp(logic [7:0] b3, logic [7:0] b2, logic [7:0] b1,
                                     logic [7:0] b0);
            logic [31:0] t;
            int          zone;
            local_time_t r;
            zone  = int'($signed(zone_reg));
            t     = {b3, b2, b1, b0} - NTP_UNIX_OFFSET;
            t     = t + 32'(zone * 3600);
            r.dst = 1'b0;
            if (dst_on && summer(t, zone))
            begin
                t     = t + 32'd3600;
                r.dst = 1'b1;
            end
            r.secs = t;
            expected_times.push_back(r);
        endfunction

        function void check_local_time(logic [31:0] secs, logic dst);
            local_time_t e;
            if (expected_times.size() == 0)
            begin
                $error("result with no transfer pending: local_seconds %0d", secs);
                failures++;
                return;
            end
            e = expected_times.pop_front();
            if (secs !== e.secs)
            begin
                $error("local_seconds: expected %0d, actual %0d", e.secs, secs);
                failures++;
            end
            if (dst !== e.dst)
            begin
                $error("dst_applied: expected %0d, actual %0d", e.dst, dst);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [7:0]  ts_byte_msb;
    logic [7:0]  ts_byte_2;
    logic [7:0]  ts_byte_1;
    logic [7:0]  ts_byte_lsb;
    logic        done;
    logic [31:0] local_seconds;
    logic        dst_applied;

    local_time_board board;
    int              idle_pct;

    ntp_timestamp_to_local_time u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .ts_byte_msb   (ts_byte_msb),
        .ts_byte_2     (ts_byte_2),
        .ts_byte_1     (ts_byte_1),
        .ts_byte_lsb   (ts_byte_lsb),
        .done          (done),
        .local_seconds (local_seconds),
        .dst_applied   (dst_applied)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            board.check_local_time(local_seconds, dst_applied);
        end
    end

    // seconds since 1970 from a civil date and hour, no month table needed
    function automatic logic [31:0] utc_seconds(int yr, int mon, int mday, int hr);
        int y;
        int era;
        int yoe;
        int doy;
        int doe;
        logic [31:0] days;
        y    = (mon <= 2) ? yr - 1 : yr;
        era  = y / 400;
        yoe  = y - era * 400;
        doy  = (153 * (mon > 2 ? mon - 3 : mon + 9) + 2) / 5 + mday - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = 32'(era * 146097 + doe - 719468);
        return days * 32'd86400 + 32'(hr) * 32'd3600;
    endfunction

    // 01:00 UTC on the last Sunday of March or October
    function automatic logic [31:0] switch_utc(int yr, bit march);
        int ls;
        ls = 31 - ((5 * yr / 4 + (march ? 4 : 1)) % 7);
        return utc_seconds(yr, march ? 3 : 10, ls, 1);
    endfunction

    task automatic send_ntp(logic [31:0] ntp);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < idle_pct);
        end
        start       <= 1'b1;
        ts_byte_msb <= ntp[31:24];
        ts_byte_2   <= ntp[23:16];
        ts_byte_1   <= ntp[15:8];
        ts_byte_lsb <= ntp[7:0];
        do
        begin
            @(posedge clk);
        end
        while (busy);
        board.note_timestamp(ntp[31:24], ntp[23:16], ntp[15:8], ntp[7:0]);
    endtask

    task automatic send_utc(logic [31:0] utc);
        send_ntp(utc + NTP_UNIX_OFFSET);
    endtask

    task automatic write_register(logic idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        board.set_register(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only once the pipeline has drained
    task automatic set_zone(logic [4:0] zone, logic dst);
        logic [31:0] noise;
        start <= 1'b0;
        while (board.expected_times.size() != 0)
        begin
            @(posedge clk);
        end
        noise = $urandom();
        write_register(REG_ZONE, {noise[31:5], zone});
        noise = $urandom();
        write_register(REG_DST, {noise[31:1], dst});
    endtask

    task automatic send_random();
        int          pick;
        int          yr;
        logic [31:0] utc;
        pick = $urandom_range(99);
        yr   = $urandom_range(2105, 1970);
        if (pick < 50)
        begin
            utc = switch_utc(yr, 1'($urandom_range(1)));
            if ($urandom_range(1) == 0)
            begin
                utc = utc + $urandom_range(6) - 3;
            end
            else
            begin
                utc = utc + $urandom_range(216000) - 108000;
            end
            send_utc(utc);
        end
        else if (pick < 65)
        begin
            utc = utc_seconds(yr, $urandom_range(12, 1), $urandom_range(28, 1),
                              $urandom_range(23));
            send_utc(utc + $urandom_range(3599));
        end
        else
        begin
            send_ntp($urandom());
        end
    endtask

    initial
    begin
        logic [4:0] zones[8];
        logic       dsts[8];
        int         idles[8];
        board       = new();
        idle_pct    = 0;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= 3'd0;
        pwdata      <= 32'd0;
        start       <= 1'b0;
        ts_byte_msb <= 8'd0;
        ts_byte_2   <= 8'd0;
        ts_byte_1   <= 8'd0;
        ts_byte_lsb <= 8'd0;
        zones = '{5'h15, 5'd13, 5'h10, 5'd15, 5'd0, 5'd1, 5'd2, 5'd0};
        dsts  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        idles = '{0, 48, 38, 0, 48, 38, 48, 0};
        zones[7] = 5'($urandom());
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zone 0, summer time off
        send_ntp(32'h0000_0000);
        send_ntp(32'hFFFF_FFFF);
        send_ntp(NTP_UNIX_OFFSET);
        send_utc(utc_seconds(2024, 7, 15, 12));

        set_zone(5'd1, 1'b1);
        send_utc(switch_utc(2024, 1'b1) - 1);
        send_utc(switch_utc(2024, 1'b1));
        send_utc(switch_utc(2024, 1'b0) - 1);
        send_utc(switch_utc(2024, 1'b0));
        send_utc(utc_seconds(2024, 7, 1, 0));
        send_utc(utc_seconds(2024, 1, 20, 5));
        send_utc(switch_utc(2100, 1'b1) - 1);
        send_utc(switch_utc(2100, 1'b1));
        send_utc(switch_utc(2105, 1'b0) - 1);
        send_utc(switch_utc(2105, 1'b0));
        // before 1970: wraps around the 32-bit range of Unix seconds
        send_ntp(32'h0000_0000);
        send_ntp(NTP_UNIX_OFFSET - 1);

        set_zone(5'h10, 1'b1);
        send_utc(switch_utc(2030, 1'b1) - 1);
        send_utc(switch_utc(2030, 1'b1));
        send_ntp(32'hFFFF_FFFF);

        set_zone(5'd15, 1'b1);
        send_utc(switch_utc(2030, 1'b0) - 1);
        send_utc(switch_utc(2030, 1'b0));
        send_ntp(32'h0000_0000);

        for (int p = 0; p < 8; p++)
        begin
            set_zone(zones[p], dsts[p]);
            idle_pct = idles[p];
            for (int i = 0; i < 179; i++)
            begin
                send_random();
            end
        end

        start <= 1'b0;
        while (board.expected_times.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
        if (board.failures == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
